// File: rtl/sfd_pkg.sv
// Package for the scale frame deframer: header codes, command codes,
// frame snapshot type and the weight limit helper. No dependencies.
`default_nettype none

package sfd_pkg;

    localparam int unsigned BODY_DEPTH   = 12;
    localparam int unsigned BODY_IDX_W   = $clog2(BODY_DEPTH);

    localparam logic [7:0] HDR_LEAD      = 8'hEF;
    localparam logic [7:0] HDR_SYNC      = 8'hDD;
    localparam logic [7:0] CMD_WEIGHT    = 8'd12;
    localparam logic [7:0] CMD_BATTERY   = 8'd8;
    localparam logic [7:0] EVT_WEIGHT    = 8'd5;
    localparam logic [7:0] EVT_EXTENDED  = 8'd11;
    localparam logic [7:0] SUB_WEIGHT    = 8'd5;
    localparam logic [1:0] SIGN_BIT      = 2'd1;

    localparam logic [6:0] BATT_MAX      = 7'd100;
    localparam logic [6:0] BATT_MASK     = 7'h7F;
    localparam logic [2:0] DEC_DEFAULT   = 3'd1;

    // frame offsets of interest
    localparam logic [8:0] OFS_COMMAND   = 9'd2;
    localparam logic [8:0] OFS_LENGTH    = 9'd3;
    localparam logic [8:0] OFS_BODY      = 9'd4;
    localparam logic [8:0] OFS_ZERO_END  = 9'd5;

    // minimum lengths for a full weight payload and for the extended subtype byte
    localparam logic [7:0] LEN_MIN_SHORT = 8'd6;
    localparam logic [7:0] LEN_MIN_EXT   = 8'd9;
    localparam logic [7:0] LEN_MIN_SUB   = 8'd3;

    localparam logic       KIND_WEIGHT   = 1'b0;
    localparam logic       KIND_BATTERY  = 1'b1;

    localparam logic [31:0] WEIGHT_LIMIT = 32'd4000;

    typedef logic [BODY_DEPTH-1:0][7:0] sfd_body_t;

    // completed frame handed from the framer to the decoder
    typedef struct packed {
        logic       valid;
        logic [7:0] command;
        logic [7:0] length;
        sfd_body_t  body;
    } sfd_frame_t;

    // big-endian count above this value means the scale sent little-endian
    function automatic logic [31:0] weight_limit(input logic [2:0] dec);
        logic [31:0] lim;
        case (dec)
            3'd2:    lim = WEIGHT_LIMIT * 32'd100;
            3'd3:    lim = WEIGHT_LIMIT * 32'd1000;
            3'd4:    lim = WEIGHT_LIMIT * 32'd10000;
            default: lim = WEIGHT_LIMIT * 32'd10;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sfd_byte_if.sv
// Byte channel into the deframer: valid, ready and one received byte.
// Depends on nothing.
`default_nettype none

interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/sfd_result_if.sv
// Result channel out of the deframer: valid, ready and one report.
// Depends on nothing.
`default_nettype none

interface sfd_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] weight_count;
    logic [2:0]  weight_decimals;
    logic        weight_negative;
    logic [6:0]  battery_percent;

    modport source (output valid, output result_kind, output weight_count,
                    output weight_decimals, output weight_negative,
                    output battery_percent, input ready);
    modport sink   (input valid, input result_kind, input weight_count,
                    input weight_decimals, input weight_negative,
                    input battery_percent, output ready);
endinterface

`default_nettype wire

// File: rtl/sfd_framer.sv
// Header hunt, byte counting and capture of command, length and body.
// Depends on sfd_pkg.
`default_nettype none

module sfd_framer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               take,
    output sfd_pkg::sfd_frame_t     frame
);

    logic                lead_seen_reg, lead_seen_next;
    logic                in_frame_reg, in_frame_next;
    logic [8:0]          byte_index_reg, byte_index_next;
    logic [7:0]          length_reg, length_next;
    logic [7:0]          command_reg, command_next;
    sfd_pkg::sfd_body_t  body_reg, body_next;
    logic                fin_valid_reg, fin_valid_next;

    logic                accept;
    logic                finish;
    logic                body_wr;
    logic [sfd_pkg::BODY_IDX_W-1:0] body_idx;

    // a finished frame waiting on a held result blocks further beats
    assign in_ready = !fin_valid_reg || take;
    assign accept   = in_valid && in_ready;

    assign body_wr  = (byte_index_reg[8:4] == 5'd0) && (byte_index_reg[3:2] != 2'd0);
    assign body_idx = sfd_pkg::BODY_IDX_W'(byte_index_reg[3:0] - 4'd4);

    always_comb
    begin
        lead_seen_next  = lead_seen_reg;
        in_frame_next   = in_frame_reg;
        byte_index_next = byte_index_reg;
        length_next     = length_reg;
        command_next    = command_reg;
        body_next       = body_reg;
        finish          = 1'b0;

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (lead_seen_reg && rx_byte == sfd_pkg::HDR_SYNC)
                begin
                    in_frame_next   = 1'b1;
                    byte_index_next = sfd_pkg::OFS_COMMAND;
                    lead_seen_next  = 1'b0;
                end
                else
                begin
                    lead_seen_next = (rx_byte == sfd_pkg::HDR_LEAD);
                end
            end
            else if (length_reg == 8'd0 && byte_index_reg == sfd_pkg::OFS_ZERO_END)
            begin
                // empty frame closes late; this beat opens the next hunt
                finish          = 1'b1;
                in_frame_next   = 1'b0;
                byte_index_next = 9'd0;
                lead_seen_next  = (rx_byte == sfd_pkg::HDR_LEAD);
            end
            else
            begin
                if (byte_index_reg == sfd_pkg::OFS_COMMAND)
                    command_next = rx_byte;
                else if (byte_index_reg == sfd_pkg::OFS_LENGTH)
                    length_next = rx_byte;
                else if (body_wr)
                begin
                    for (int i = 0; i < sfd_pkg::BODY_DEPTH; i++)
                    begin
                        if (body_idx == sfd_pkg::BODY_IDX_W'(i))
                            body_next[i] = rx_byte;
                    end
                end

                if (byte_index_reg >= sfd_pkg::OFS_BODY && length_reg != 8'd0 &&
                    byte_index_reg == ({1'b0, length_reg} + sfd_pkg::OFS_BODY))
                begin
                    finish          = 1'b1;
                    in_frame_next   = 1'b0;
                    byte_index_next = 9'd0;
                    lead_seen_next  = 1'b0;
                end
                else
                begin
                    byte_index_next = byte_index_reg + 9'd1;
                end
            end
        end

        if (finish)
            fin_valid_next = 1'b1;
        else if (take)
            fin_valid_next = 1'b0;
        else
            fin_valid_next = fin_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_seen_reg  <= 1'b0;
            in_frame_reg   <= 1'b0;
            byte_index_reg <= 9'd0;
            fin_valid_reg  <= 1'b0;
        end
        else
        begin
            lead_seen_reg  <= lead_seen_next;
            in_frame_reg   <= in_frame_next;
            byte_index_reg <= byte_index_next;
            fin_valid_reg  <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        length_reg  <= length_next;
        command_reg <= command_next;
        body_reg    <= body_next;
    end

    assign frame.valid   = fin_valid_reg;
    assign frame.command = command_reg;
    assign frame.length  = length_reg;
    assign frame.body    = body_reg;

endmodule

`default_nettype wire

// File: rtl/sfd_decode.sv
// Report decode of a finished frame and the result register.
// Depends on sfd_pkg.
`default_nettype none

module sfd_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sfd_pkg::sfd_frame_t frame,
    output logic                     take,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     result_kind,
    output logic [31:0]              weight_count,
    output logic [2:0]               weight_decimals,
    output logic                     weight_negative,
    output logic [6:0]               battery_percent
);

    logic        out_valid_reg;
    logic        kind_reg, kind_next;
    logic [31:0] count_reg, count_next;
    logic [2:0]  dec_reg, dec_next;
    logic        neg_reg, neg_next;
    logic [6:0]  batt_reg, batt_next;

    logic        is_weight, is_battery, evt_short, evt_ext, short_pl, has_result;
    logic [5:0][7:0] pl;
    logic [2:0]  dec;
    logic [31:0] be, le;
    logic [6:0]  batt_raw;

    assign take = !out_valid_reg || out_ready;

    assign evt_short  = frame.body[0] == sfd_pkg::EVT_WEIGHT;
    assign evt_ext    = frame.body[0] == sfd_pkg::EVT_EXTENDED &&
                        frame.length >= sfd_pkg::LEN_MIN_SUB &&
                        frame.body[3] == sfd_pkg::SUB_WEIGHT;
    assign is_weight  = frame.command == sfd_pkg::CMD_WEIGHT && (evt_short || evt_ext);
    assign is_battery = frame.command == sfd_pkg::CMD_BATTERY;
    assign has_result = is_weight || is_battery;

    // extended events carry three extra bytes ahead of the payload
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            pl[k] = evt_short ? frame.body[1 + k] : frame.body[4 + k];
    end

    assign short_pl = evt_short ? (frame.length < sfd_pkg::LEN_MIN_SHORT)
                                : (frame.length < sfd_pkg::LEN_MIN_EXT);

    assign dec = (pl[4] >= 8'd1 && pl[4] <= 8'd4) ? pl[4][2:0] : sfd_pkg::DEC_DEFAULT;
    assign be  = {pl[0], pl[1], pl[2], pl[3]};
    assign le  = {pl[3], pl[2], pl[1], pl[0]};

    assign batt_raw = frame.body[0][6:0] & sfd_pkg::BATT_MASK;

    always_comb
    begin
        kind_next  = sfd_pkg::KIND_WEIGHT;
        count_next = 32'd0;
        dec_next   = sfd_pkg::DEC_DEFAULT;
        neg_next   = 1'b0;
        batt_next  = 7'd0;
        if (is_battery)
        begin
            kind_next = sfd_pkg::KIND_BATTERY;
            batt_next = (batt_raw > sfd_pkg::BATT_MAX) ? sfd_pkg::BATT_MAX : batt_raw;
        end
        else if (!short_pl)
        begin
            count_next = (be > sfd_pkg::weight_limit(dec)) ? le : be;
            dec_next   = dec;
            neg_next   = pl[5][sfd_pkg::SIGN_BIT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= frame.valid && has_result;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind_next;
            count_reg <= count_next;
            dec_reg   <= dec_next;
            neg_reg   <= neg_next;
            batt_reg  <= batt_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign weight_count    = count_reg;
    assign weight_decimals = dec_reg;
    assign weight_negative = neg_reg;
    assign battery_percent = batt_reg;

endmodule

`default_nettype wire

// File: rtl/scale_frame_deframer_top.sv
// Scale frame deframer: one received byte per beat, weight and battery reports out.
// A report leaves through the finish register, then the result register, after the
// frame's last beat; an empty frame closes on the beat that follows it.
// Throughput: one byte per cycle; input stalls only while a closed frame waits
// behind a result beat that has not been taken (finish register, result register).
// Reset (rst_n, async, active low) clears the hunt, frame position and valid flags.
`default_nettype none

module scale_frame_deframer_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sfd_byte_if.sink    byte_ch,
    sfd_result_if.source result_ch
);

    sfd_pkg::sfd_frame_t frame;
    logic                take;

    sfd_framer u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_ready (byte_ch.ready),
        .rx_byte  (byte_ch.rx_byte),
        .take     (take),
        .frame    (frame)
    );

    sfd_decode u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame           (frame),
        .take            (take),
        .out_valid       (result_ch.valid),
        .out_ready       (result_ch.ready),
        .result_kind     (result_ch.result_kind),
        .weight_count    (result_ch.weight_count),
        .weight_decimals (result_ch.weight_decimals),
        .weight_negative (result_ch.weight_negative),
        .battery_percent (result_ch.battery_percent)
    );

endmodule

`default_nettype wire

// File: rtl/sfd_checker.sv
// Port-level checks for the deframer and the bind that attaches them.
// Depends on sfd_pkg and scale_frame_deframer_top.
`default_nettype none

module sfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        result_kind,
    input wire logic [31:0] weight_count,
    input wire logic [2:0]  weight_decimals,
    input wire logic        weight_negative,
    input wire logic [6:0]  battery_percent
);

    // a held result beat stays valid and keeps its kind, weight count and battery level
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight_count) &&
        $stable(result_kind) && $stable(battery_percent))
        else $error("result beat changed while stalled");

    a_battery_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == sfd_pkg::KIND_BATTERY |->
        weight_count == 32'd0 && weight_decimals == sfd_pkg::DEC_DEFAULT &&
        !weight_negative && battery_percent <= sfd_pkg::BATT_MAX)
        else $error("battery report with weight fields set or level over cap");

    a_weight_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == sfd_pkg::KIND_WEIGHT |->
        battery_percent == 7'd0 && weight_decimals >= 3'd1 && weight_decimals <= 3'd4)
        else $error("weight report with bad decimals or battery set");

    // nothing offered while reset is held
    a_idle_in_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result beat offered during reset");

endmodule

bind scale_frame_deframer_top sfd_checker u_sfd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result_ch.valid),
    .out_ready       (result_ch.ready),
    .result_kind     (result_ch.result_kind),
    .weight_count    (result_ch.weight_count),
    .weight_decimals (result_ch.weight_decimals),
    .weight_negative (result_ch.weight_negative),
    .battery_percent (result_ch.battery_percent)
);

`default_nettype wire
